// ===== hdl/bpp_pkg.sv =====
// Shared types, constants and the push program for the ponderomotive Boris momentum pusher.
package bpp_pkg;

    localparam int WORD_BITS  = 32;
    localparam int FRAC_BITS  = 16;
    localparam int GAMMA_FRAC = 16;
    localparam int VAL_BITS   = 64;

    typedef logic signed [VAL_BITS-1:0] val_t;

    localparam val_t INNER_LIM = val_t'((64'd1 << 62) - 64'd1);
    localparam val_t ONE_VAL   = val_t'(64'd1 << FRAC_BITS);
    localparam val_t WORD_MAX  = val_t'((64'd1 << (WORD_BITS - 1)) - 64'd1);
    localparam val_t WORD_MIN  = -WORD_MAX - val_t'(1);

    // Configuration register indexes.
    localparam logic [1:0] CFG_INV_MASS   = 2'd0;
    localparam logic [1:0] CFG_HALF_DT    = 2'd1;
    localparam logic [1:0] CFG_QUARTER_DT = 2'd2;

    typedef enum logic [1:0] {SH_NONE, SH_FRAC, SH_GAMMA} sh_t;
    typedef enum logic [2:0] {OP_ADD, OP_SUB, OP_MUL, OP_RECIP, OP_OUT} op_kind_t;

    typedef logic [5:0] src_t;
    typedef logic [4:0] slot_t;

    typedef struct packed {
        op_kind_t kind;
        src_t     src_a;
        src_t     src_b;
        slot_t    dst;
        sh_t      sh;
    } op_t;

    // Response of a multi-cycle arithmetic unit.
    typedef struct packed {
        logic done;
        logic sat;
        val_t value;
    } unit_rsp_t;

    localparam int PC_BITS = 7;
    typedef logic [PC_BITS-1:0] pc_t;
    localparam pc_t PROG_LAST = 7'd76;

    // Scratch memory slots.
    localparam src_t S_T0    = 6'd0;
    localparam src_t S_C1    = 6'd1;
    localparam src_t S_T2    = 6'd2;
    localparam src_t S_C2    = 6'd3;
    localparam src_t S_T4    = 6'd4;
    localparam src_t S_T5    = 6'd5;
    localparam src_t S_K0    = 6'd6;
    localparam src_t S_K1    = 6'd7;
    localparam src_t S_K2    = 6'd8;
    localparam src_t S_U0    = 6'd9;
    localparam src_t S_U1    = 6'd10;
    localparam src_t S_U2    = 6'd11;
    localparam src_t S_ALPHA = 6'd12;
    localparam src_t S_TX    = 6'd13;
    localparam src_t S_TY    = 6'd14;
    localparam src_t S_TZ    = 6'd15;
    localparam src_t S_X2    = 6'd16;
    localparam src_t S_Y2    = 6'd17;
    localparam src_t S_Z2    = 6'd18;
    localparam src_t S_XY    = 6'd19;
    localparam src_t S_YZ    = 6'd20;
    localparam src_t S_ZX    = 6'd21;
    localparam src_t S_INV   = 6'd22;
    localparam src_t S_R11   = 6'd23;
    localparam src_t S_R22   = 6'd24;
    localparam src_t S_R33   = 6'd25;
    localparam src_t S_R12   = 6'd26;
    localparam src_t S_R13   = 6'd27;
    localparam src_t S_R21   = 6'd28;
    localparam src_t S_R23   = 6'd29;
    localparam src_t S_R31   = 6'd30;
    localparam src_t S_R32   = 6'd31;

    // Operands held in registers rather than in scratch memory.
    localparam src_t SRC_A0  = 6'd32;
    localparam src_t SRC_A1  = 6'd33;
    localparam src_t SRC_A2  = 6'd34;
    localparam src_t SRC_B0  = 6'd35;
    localparam src_t SRC_B1  = 6'd36;
    localparam src_t SRC_B2  = 6'd37;
    localparam src_t SRC_E0  = 6'd38;
    localparam src_t SRC_E1  = 6'd39;
    localparam src_t SRC_E2  = 6'd40;
    localparam src_t SRC_HB0 = 6'd41;
    localparam src_t SRC_HB1 = 6'd42;
    localparam src_t SRC_HB2 = 6'd43;
    localparam src_t SRC_Q   = 6'd44;
    localparam src_t SRC_G   = 6'd45;
    localparam src_t SRC_IM  = 6'd46;
    localparam src_t SRC_HDT = 6'd47;
    localparam src_t SRC_QDT = 6'd48;
    localparam src_t SRC_ONE = 6'd49;

    function automatic op_t mk(input op_kind_t kind, input src_t a, input src_t b,
                               input src_t dst, input sh_t sh);
        op_t op;
        op.kind  = kind;
        op.src_a = a;
        op.src_b = b;
        op.dst   = dst[4:0];
        op.sh    = sh;
        return op;
    endfunction

    // The push as a sequence of operations on the shared units.
    function automatic op_t prog_op(input pc_t pc);
        op_t op;
        case (pc)
            7'd0:  op = mk(OP_MUL, SRC_IM, SRC_HDT, S_T0, SH_FRAC);
            7'd1:  op = mk(OP_MUL, SRC_Q, S_T0, S_C1, SH_NONE);
            7'd2:  op = mk(OP_MUL, SRC_IM, SRC_IM, S_T0, SH_FRAC);
            7'd3:  op = mk(OP_MUL, S_T0, SRC_QDT, S_T0, SH_FRAC);
            7'd4:  op = mk(OP_MUL, SRC_Q, SRC_Q, S_T2, SH_NONE);
            7'd5:  op = mk(OP_MUL, S_T2, S_T0, S_C2, SH_NONE);
            7'd6:  op = mk(OP_MUL, S_C1, SRC_E0, S_T4, SH_FRAC);
            7'd7:  op = mk(OP_MUL, S_C2, SRC_B0, S_T5, SH_FRAC);
            7'd8:  op = mk(OP_MUL, S_T5, SRC_G, S_T5, SH_GAMMA);
            7'd9:  op = mk(OP_SUB, S_T4, S_T5, S_K0, SH_NONE);
            7'd10: op = mk(OP_ADD, SRC_A0, S_K0, S_U0, SH_NONE);
            7'd11: op = mk(OP_MUL, S_C1, SRC_E1, S_T4, SH_FRAC);
            7'd12: op = mk(OP_MUL, S_C2, SRC_B1, S_T5, SH_FRAC);
            7'd13: op = mk(OP_MUL, S_T5, SRC_G, S_T5, SH_GAMMA);
            7'd14: op = mk(OP_SUB, S_T4, S_T5, S_K1, SH_NONE);
            7'd15: op = mk(OP_ADD, SRC_A1, S_K1, S_U1, SH_NONE);
            7'd16: op = mk(OP_MUL, S_C1, SRC_E2, S_T4, SH_FRAC);
            7'd17: op = mk(OP_MUL, S_C2, SRC_B2, S_T5, SH_FRAC);
            7'd18: op = mk(OP_MUL, S_T5, SRC_G, S_T5, SH_GAMMA);
            7'd19: op = mk(OP_SUB, S_T4, S_T5, S_K2, SH_NONE);
            7'd20: op = mk(OP_ADD, SRC_A2, S_K2, S_U2, SH_NONE);
            7'd21: op = mk(OP_MUL, S_C1, SRC_G, S_ALPHA, SH_GAMMA);
            7'd22: op = mk(OP_MUL, S_ALPHA, SRC_HB0, S_TX, SH_FRAC);
            7'd23: op = mk(OP_MUL, S_ALPHA, SRC_HB1, S_TY, SH_FRAC);
            7'd24: op = mk(OP_MUL, S_ALPHA, SRC_HB2, S_TZ, SH_FRAC);
            7'd25: op = mk(OP_MUL, S_TX, S_TX, S_X2, SH_FRAC);
            7'd26: op = mk(OP_MUL, S_TY, S_TY, S_Y2, SH_FRAC);
            7'd27: op = mk(OP_MUL, S_TZ, S_TZ, S_Z2, SH_FRAC);
            7'd28: op = mk(OP_MUL, S_TX, S_TY, S_XY, SH_FRAC);
            7'd29: op = mk(OP_MUL, S_TY, S_TZ, S_YZ, SH_FRAC);
            7'd30: op = mk(OP_MUL, S_TZ, S_TX, S_ZX, SH_FRAC);
            7'd31: op = mk(OP_ADD, SRC_ONE, S_X2, S_T0, SH_NONE);
            7'd32: op = mk(OP_ADD, S_T0, S_Y2, S_T0, SH_NONE);
            7'd33: op = mk(OP_ADD, S_T0, S_Z2, S_T0, SH_NONE);
            7'd34: op = mk(OP_RECIP, S_T0, S_T0, S_INV, SH_NONE);
            7'd35: op = mk(OP_ADD, SRC_ONE, S_X2, S_T0, SH_NONE);
            7'd36: op = mk(OP_SUB, S_T0, S_Y2, S_T0, SH_NONE);
            7'd37: op = mk(OP_SUB, S_T0, S_Z2, S_R11, SH_NONE);
            7'd38: op = mk(OP_SUB, SRC_ONE, S_X2, S_T0, SH_NONE);
            7'd39: op = mk(OP_ADD, S_T0, S_Y2, S_T0, SH_NONE);
            7'd40: op = mk(OP_SUB, S_T0, S_Z2, S_R22, SH_NONE);
            7'd41: op = mk(OP_SUB, SRC_ONE, S_X2, S_T0, SH_NONE);
            7'd42: op = mk(OP_SUB, S_T0, S_Y2, S_T0, SH_NONE);
            7'd43: op = mk(OP_ADD, S_T0, S_Z2, S_R33, SH_NONE);
            7'd44: op = mk(OP_ADD, S_XY, S_TZ, S_T0, SH_NONE);
            7'd45: op = mk(OP_ADD, S_T0, S_T0, S_R12, SH_NONE);
            7'd46: op = mk(OP_SUB, S_ZX, S_TY, S_T0, SH_NONE);
            7'd47: op = mk(OP_ADD, S_T0, S_T0, S_R13, SH_NONE);
            7'd48: op = mk(OP_SUB, S_XY, S_TZ, S_T0, SH_NONE);
            7'd49: op = mk(OP_ADD, S_T0, S_T0, S_R21, SH_NONE);
            7'd50: op = mk(OP_ADD, S_YZ, S_TX, S_T0, SH_NONE);
            7'd51: op = mk(OP_ADD, S_T0, S_T0, S_R23, SH_NONE);
            7'd52: op = mk(OP_ADD, S_ZX, S_TY, S_T0, SH_NONE);
            7'd53: op = mk(OP_ADD, S_T0, S_T0, S_R31, SH_NONE);
            7'd54: op = mk(OP_SUB, S_YZ, S_TX, S_T0, SH_NONE);
            7'd55: op = mk(OP_ADD, S_T0, S_T0, S_R32, SH_NONE);
            7'd56: op = mk(OP_MUL, S_R11, S_U0, S_T2, SH_FRAC);
            7'd57: op = mk(OP_MUL, S_R12, S_U1, S_T4, SH_FRAC);
            7'd58: op = mk(OP_ADD, S_T2, S_T4, S_T2, SH_NONE);
            7'd59: op = mk(OP_MUL, S_R13, S_U2, S_T4, SH_FRAC);
            7'd60: op = mk(OP_ADD, S_T2, S_T4, S_T2, SH_NONE);
            7'd61: op = mk(OP_MUL, S_T2, S_INV, S_T2, SH_FRAC);
            7'd62: op = mk(OP_OUT, S_K0, S_T2, 6'd0, SH_NONE);
            7'd63: op = mk(OP_MUL, S_R21, S_U0, S_T2, SH_FRAC);
            7'd64: op = mk(OP_MUL, S_R22, S_U1, S_T4, SH_FRAC);
            7'd65: op = mk(OP_ADD, S_T2, S_T4, S_T2, SH_NONE);
            7'd66: op = mk(OP_MUL, S_R23, S_U2, S_T4, SH_FRAC);
            7'd67: op = mk(OP_ADD, S_T2, S_T4, S_T2, SH_NONE);
            7'd68: op = mk(OP_MUL, S_T2, S_INV, S_T2, SH_FRAC);
            7'd69: op = mk(OP_OUT, S_K1, S_T2, 6'd1, SH_NONE);
            7'd70: op = mk(OP_MUL, S_R31, S_U0, S_T2, SH_FRAC);
            7'd71: op = mk(OP_MUL, S_R32, S_U1, S_T4, SH_FRAC);
            7'd72: op = mk(OP_ADD, S_T2, S_T4, S_T2, SH_NONE);
            7'd73: op = mk(OP_MUL, S_R33, S_U2, S_T4, SH_FRAC);
            7'd74: op = mk(OP_ADD, S_T2, S_T4, S_T2, SH_NONE);
            7'd75: op = mk(OP_MUL, S_T2, S_INV, S_T2, SH_FRAC);
            7'd76: op = mk(OP_OUT, S_K2, S_T2, 6'd2, SH_NONE);
            default: op = mk(OP_ADD, S_T0, S_T0, S_T0, SH_NONE);
        endcase
        return op;
    endfunction

endpackage

// ===== hdl/bpp_mul.sv =====
// Multi-cycle fixed-point multiplier with rounding shift and clamp on one 32x32 multiplier.
module bpp_mul
    import bpp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  val_t      a,
    input  val_t      b,
    input  sh_t       sh,
    output unit_rsp_t rsp
);

    typedef enum logic [1:0] {M_IDLE, M_MUL, M_ROUND, M_FINISH} mstate_t;

    mstate_t      state_reg;
    logic [63:0]  ua_reg;
    logic [63:0]  ub_reg;
    logic         neg_reg;
    sh_t          sh_reg;
    logic [2:0]   cnt_reg;
    logic [63:0]  pp_reg;
    logic [1:0]   pp_pos_reg;
    logic [127:0] acc_reg;
    logic [127:0] rnd_reg;
    unit_rsp_t    rsp_reg;

    logic [31:0]  a_half;
    logic [31:0]  b_half;
    logic [127:0] pp_placed;
    logic [127:0] rnd_next;
    logic         big;
    logic [63:0]  mag;

    assign a_half = cnt_reg[1] ? ua_reg[63:32] : ua_reg[31:0];
    assign b_half = cnt_reg[0] ? ub_reg[63:32] : ub_reg[31:0];

    always_comb
    begin
        case (pp_pos_reg)
            2'd0:    pp_placed = {64'd0, pp_reg};
            2'd1:    pp_placed = {32'd0, pp_reg, 32'd0};
            2'd2:    pp_placed = {pp_reg, 64'd0};
            default: pp_placed = 128'd0;
        endcase
    end

    always_comb
    begin
        case (sh_reg)
            SH_FRAC:  rnd_next = (acc_reg + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
            SH_GAMMA: rnd_next = (acc_reg + (128'd1 << (GAMMA_FRAC - 1))) >> GAMMA_FRAC;
            default:  rnd_next = acc_reg;
        endcase
    end

    // Anything at or above 2^62 exceeds the inner limit.
    assign big = |rnd_reg[127:62];
    assign mag = big ? 64'(INNER_LIM) : rnd_reg[63:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= M_IDLE;
            rsp_reg.done <= 1'b0;
        end
        else
        begin
            rsp_reg.done <= 1'b0;
            case (state_reg)
                M_IDLE:
                begin
                    if (start)
                    begin
                        ua_reg    <= a[VAL_BITS-1] ? 64'(-a) : 64'(a);
                        ub_reg    <= b[VAL_BITS-1] ? 64'(-b) : 64'(b);
                        neg_reg   <= a[VAL_BITS-1] ^ b[VAL_BITS-1];
                        sh_reg    <= sh;
                        cnt_reg   <= 3'd0;
                        acc_reg   <= 128'd0;
                        state_reg <= M_MUL;
                    end
                end
                M_MUL:
                begin
                    if (cnt_reg != 3'd4)
                    begin
                        pp_reg     <= a_half * b_half;
                        pp_pos_reg <= 2'(cnt_reg[1]) + 2'(cnt_reg[0]);
                    end
                    if (cnt_reg != 3'd0)
                    begin
                        acc_reg <= acc_reg + pp_placed;
                    end
                    if (cnt_reg == 3'd4)
                    begin
                        state_reg <= M_ROUND;
                    end
                    cnt_reg <= cnt_reg + 3'd1;
                end
                M_ROUND:
                begin
                    rnd_reg   <= rnd_next;
                    state_reg <= M_FINISH;
                end
                M_FINISH:
                begin
                    rsp_reg.done  <= 1'b1;
                    rsp_reg.sat   <= big;
                    rsp_reg.value <= neg_reg ? -val_t'(mag) : val_t'(mag);
                    state_reg     <= M_IDLE;
                end
                default:
                begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

    assign rsp = rsp_reg;

endmodule

// ===== hdl/bpp_recip.sv =====
// Restoring divider that forms the rounded reciprocal of the Boris denominator.
module bpp_recip
    import bpp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  val_t      d,
    output unit_rsp_t rsp
);

    localparam int STEPS    = 2 * FRAC_BITS;
    localparam int CNT_BITS = $clog2(STEPS + 1);
    localparam int Q_BITS   = STEPS + 2;

    typedef enum logic [1:0] {R_IDLE, R_STEP, R_ROUND} rstate_t;

    rstate_t             state_reg;
    logic [63:0]         ud_reg;
    logic [63:0]         rem_reg;
    logic [Q_BITS-1:0]   q_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    unit_rsp_t           rsp_reg;

    logic [63:0] rem_sh;
    logic        ge;

    // The dividend is a single one bit at the top, fed in on the first step.
    assign rem_sh = {rem_reg[62:0], (cnt_reg == CNT_BITS'(STEPS))};
    assign ge     = rem_sh >= ud_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= R_IDLE;
            rsp_reg.done <= 1'b0;
        end
        else
        begin
            rsp_reg.done <= 1'b0;
            case (state_reg)
                R_IDLE:
                begin
                    if (start)
                    begin
                        ud_reg    <= 64'(d);
                        rem_reg   <= 64'd0;
                        q_reg     <= '0;
                        cnt_reg   <= CNT_BITS'(STEPS);
                        state_reg <= R_STEP;
                    end
                end
                R_STEP:
                begin
                    rem_reg <= ge ? rem_sh - ud_reg : rem_sh;
                    q_reg   <= {q_reg[Q_BITS-2:0], ge};
                    if (cnt_reg == '0)
                    begin
                        state_reg <= R_ROUND;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - CNT_BITS'(1);
                    end
                end
                R_ROUND:
                begin
                    rsp_reg.done  <= 1'b1;
                    rsp_reg.sat   <= 1'b0;
                    rsp_reg.value <= val_t'(q_reg) +
                                     val_t'(rem_reg >= (ud_reg - rem_reg));
                    state_reg     <= R_IDLE;
                end
                default:
                begin
                    state_reg <= R_IDLE;
                end
            endcase
        end
    end

    assign rsp = rsp_reg;

endmodule

// ===== hdl/ponderomotive_boris_momentum_push.sv =====
// Top level of the ponderomotive Boris momentum pusher: sequencer, scratch memory and ports.
//
//   channel   direction  handshake                what moves
//   --------  ---------  -----------------------  ----------------------------------------
//   cfg       in         cfg_wr_en                inv_mass, half_dt, quarter_dt writes
//   in        in         in_valid / in_stall      mode, two vectors, charge, inverse gamma
//   out       out        out_valid / out_stall    new momentum vector and overflow flag
//
// A mode-0 transaction loads E and B and the block is ready again at once.
// A mode-1 transaction runs a 77-step program on one shared multiplier (37 multiplies),
// one saturating adder and a restoring divider for the reciprocal.
// Reset clears the configuration registers to their defaults, the held E and B vectors
// to zero, and all control state. A result waits in the output register while out_stall
// is high; the next input transaction can already be taken and worked on meanwhile.
module ponderomotive_boris_momentum_push
    import bpp_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [1:0]                  cfg_index,
    input  logic [31:0]                 cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        mode,
    input  logic signed [31:0]          vec_a_x,
    input  logic signed [31:0]          vec_a_y,
    input  logic signed [31:0]          vec_a_z,
    input  logic signed [31:0]          vec_b_x,
    input  logic signed [31:0]          vec_b_y,
    input  logic signed [31:0]          vec_b_z,
    input  logic signed [7:0]           particle_charge,
    input  logic [16:0]                 inv_gamma,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [WORD_BITS-1:0] new_mom_x,
    output logic signed [WORD_BITS-1:0] new_mom_y,
    output logic signed [WORD_BITS-1:0] new_mom_z,
    output logic                        overflow
);

    typedef enum logic [2:0] {S_IDLE, S_READ, S_OPER, S_EXEC, S_WAIT, S_DONE} state_t;

    state_t state_reg;
    pc_t    pc_reg;

    // Configuration registers.
    logic [31:0] inv_mass_reg;
    logic [30:0] half_dt_reg;
    logic [30:0] quarter_dt_reg;

    // Held fields and the particle being pushed.
    logic signed [31:0] held_e_reg [0:2];
    logic signed [31:0] held_b_reg [0:2];
    logic signed [31:0] a_reg      [0:2];
    logic signed [31:0] b_reg      [0:2];
    logic signed [7:0]  q_reg;
    logic [16:0]        g_reg;

    // Operand and result registers.
    val_t opa_reg;
    val_t opb_reg;
    logic sat_reg;
    logic signed [WORD_BITS-1:0] res_reg [0:2];

    logic                        out_valid_reg;
    logic signed [WORD_BITS-1:0] out_x_reg;
    logic signed [WORD_BITS-1:0] out_y_reg;
    logic signed [WORD_BITS-1:0] out_z_reg;
    logic                        out_ovf_reg;

    // Scratch memory for intermediates.
    val_t tmp_mem [0:31];
    val_t rd_a_reg;
    val_t rd_b_reg;

    op_t       cur_op;
    logic      in_accept;
    logic      mul_start;
    logic      div_start;
    unit_rsp_t mul_rsp;
    unit_rsp_t div_rsp;
    logic      unit_done;
    logic      unit_sat;
    val_t      unit_value;
    logic      exec_simple;
    logic      advance;
    logic      step_sat;
    logic      mem_we;
    val_t      mem_wdata;

    val_t sum_raw;
    val_t add_val;
    logic add_sat;
    logic out_sat;
    logic signed [WORD_BITS-1:0] out_word;

    assign cur_op    = prog_op(pc_reg);
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;

    // Operand select: scratch slots come from memory, the rest from registers.
    function automatic val_t pick(input src_t s, input val_t rd);
        val_t v;
        case (s)
            SRC_A0:  v = val_t'(a_reg[0]);
            SRC_A1:  v = val_t'(a_reg[1]);
            SRC_A2:  v = val_t'(a_reg[2]);
            SRC_B0:  v = val_t'(b_reg[0]);
            SRC_B1:  v = val_t'(b_reg[1]);
            SRC_B2:  v = val_t'(b_reg[2]);
            SRC_E0:  v = val_t'(held_e_reg[0]);
            SRC_E1:  v = val_t'(held_e_reg[1]);
            SRC_E2:  v = val_t'(held_e_reg[2]);
            SRC_HB0: v = val_t'(held_b_reg[0]);
            SRC_HB1: v = val_t'(held_b_reg[1]);
            SRC_HB2: v = val_t'(held_b_reg[2]);
            SRC_Q:   v = val_t'(q_reg);
            SRC_G:   v = val_t'({1'b0, g_reg});
            SRC_IM:  v = val_t'({1'b0, inv_mass_reg});
            SRC_HDT: v = val_t'({1'b0, half_dt_reg});
            SRC_QDT: v = val_t'({1'b0, quarter_dt_reg});
            SRC_ONE: v = ONE_VAL;
            default: v = rd;
        endcase
        return v;
    endfunction

    // Saturating adder, plus the final clamp to a momentum word.
    always_comb
    begin
        sum_raw = (cur_op.kind == OP_SUB) ? opa_reg - opb_reg : opa_reg + opb_reg;
        add_val = sum_raw;
        add_sat = 1'b0;
        if (sum_raw > INNER_LIM)
        begin
            add_val = INNER_LIM;
            add_sat = 1'b1;
        end
        else if (sum_raw < -INNER_LIM)
        begin
            add_val = -INNER_LIM;
            add_sat = 1'b1;
        end
        out_sat  = add_sat;
        out_word = add_val[WORD_BITS-1:0];
        if (add_val > WORD_MAX)
        begin
            out_word = WORD_MAX[WORD_BITS-1:0];
            out_sat  = 1'b1;
        end
        else if (add_val < WORD_MIN)
        begin
            out_word = WORD_MIN[WORD_BITS-1:0];
            out_sat  = 1'b1;
        end
    end

    assign mul_start = (state_reg == S_EXEC) && (cur_op.kind == OP_MUL);
    assign div_start = (state_reg == S_EXEC) && (cur_op.kind == OP_RECIP);

    bpp_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (opa_reg),
        .b     (opb_reg),
        .sh    (cur_op.sh),
        .rsp   (mul_rsp)
    );

    bpp_recip u_recip (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .d     (opa_reg),
        .rsp   (div_rsp)
    );

    assign unit_done  = (cur_op.kind == OP_MUL) ? mul_rsp.done  : div_rsp.done;
    assign unit_sat   = (cur_op.kind == OP_MUL) ? mul_rsp.sat   : div_rsp.sat;
    assign unit_value = (cur_op.kind == OP_MUL) ? mul_rsp.value : div_rsp.value;

    assign exec_simple = (state_reg == S_EXEC) &&
                         ((cur_op.kind == OP_ADD) || (cur_op.kind == OP_SUB) ||
                          (cur_op.kind == OP_OUT));
    assign advance     = exec_simple || ((state_reg == S_WAIT) && unit_done);

    always_comb
    begin
        step_sat = 1'b0;
        if (state_reg == S_WAIT)
        begin
            step_sat = unit_sat;
        end
        else if (cur_op.kind == OP_OUT)
        begin
            step_sat = out_sat;
        end
        else
        begin
            step_sat = add_sat;
        end
    end

    assign mem_we    = (exec_simple && (cur_op.kind != OP_OUT)) ||
                       ((state_reg == S_WAIT) && unit_done);
    assign mem_wdata = (state_reg == S_WAIT) ? unit_value : add_val;

    // Scratch memory: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        rd_a_reg <= tmp_mem[cur_op.src_a[4:0]];
        rd_b_reg <= tmp_mem[cur_op.src_b[4:0]];
        if (mem_we)
        begin
            tmp_mem[cur_op.dst] <= mem_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pc_reg         <= '0;
            sat_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            inv_mass_reg   <= 32'd65536;
            half_dt_reg    <= '0;
            quarter_dt_reg <= '0;
            for (int i = 0; i < 3; i++)
            begin
                held_e_reg[i] <= '0;
                held_b_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_INV_MASS:   inv_mass_reg   <= cfg_data;
                    CFG_HALF_DT:    half_dt_reg    <= cfg_data[30:0];
                    CFG_QUARTER_DT: quarter_dt_reg <= cfg_data[30:0];
                    default:        ;
                endcase
            end

            // In the done state the output register is refilled below instead.
            if (out_valid_reg && !out_stall && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        if (!mode)
                        begin
                            held_e_reg[0] <= vec_a_x;
                            held_e_reg[1] <= vec_a_y;
                            held_e_reg[2] <= vec_a_z;
                            held_b_reg[0] <= vec_b_x;
                            held_b_reg[1] <= vec_b_y;
                            held_b_reg[2] <= vec_b_z;
                        end
                        else
                        begin
                            a_reg[0]  <= vec_a_x;
                            a_reg[1]  <= vec_a_y;
                            a_reg[2]  <= vec_a_z;
                            b_reg[0]  <= vec_b_x;
                            b_reg[1]  <= vec_b_y;
                            b_reg[2]  <= vec_b_z;
                            q_reg     <= particle_charge;
                            g_reg     <= inv_gamma;
                            pc_reg    <= '0;
                            sat_reg   <= 1'b0;
                            state_reg <= S_READ;
                        end
                    end
                end
                S_READ:
                begin
                    state_reg <= S_OPER;
                end
                S_OPER:
                begin
                    opa_reg   <= pick(cur_op.src_a, rd_a_reg);
                    opb_reg   <= pick(cur_op.src_b, rd_b_reg);
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    if ((cur_op.kind == OP_MUL) || (cur_op.kind == OP_RECIP))
                    begin
                        state_reg <= S_WAIT;
                    end
                    if (cur_op.kind == OP_OUT)
                    begin
                        res_reg[cur_op.dst[1:0]] <= out_word;
                    end
                end
                S_WAIT:
                begin
                end
                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        out_x_reg     <= res_reg[0];
                        out_y_reg     <= res_reg[1];
                        out_z_reg     <= res_reg[2];
                        out_ovf_reg   <= sat_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // Step completion: collect saturation and move to the next program step.
            if (advance)
            begin
                sat_reg <= sat_reg | step_sat;
                if (pc_reg == PROG_LAST)
                begin
                    state_reg <= S_DONE;
                end
                else
                begin
                    pc_reg    <= pc_reg + pc_t'(1);
                    state_reg <= S_READ;
                end
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign new_mom_x = out_x_reg;
    assign new_mom_y = out_y_reg;
    assign new_mom_z = out_z_reg;
    assign overflow  = out_ovf_reg;

    // The program counter never runs past the last step.
    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg <= PROG_LAST)
        else $error("program counter beyond last step");

    // A unit answers only while the sequencer waits for it.
    a_unit_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (mul_rsp.done || div_rsp.done) |-> (state_reg == S_WAIT))
        else $error("unit response outside wait state");

    // A new result appears only after the program has finished.
    a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised without finished push");

endmodule

// ===== verif/tb_ponderomotive_boris_momentum_push.sv =====
// Self-checking testbench for the ponderomotive Boris momentum pusher.
`timescale 1ns / 100ps

module tb_ponderomotive_boris_momentum_push;
    import bpp_pkg::*;

    // One input transaction as the driver holds it.
    typedef struct packed {
        logic             mode;
        logic [2:0][31:0] a;
        logic [2:0][31:0] b;
        logic [7:0]       q;
        logic [16:0]      g;
    } push_item_t;

    // One result transaction: the new momentum and the saturation flag.
    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        ovf;
    } momentum_t;

    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 60;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        mode;
    logic signed [31:0] vec_a_x, vec_a_y, vec_a_z;
    logic signed [31:0] vec_b_x, vec_b_y, vec_b_z;
    logic signed [7:0]  particle_charge;
    logic [16:0] inv_gamma;
    logic        out_valid;
    logic        out_stall;
    logic signed [WORD_BITS-1:0] new_mom_x, new_mom_y, new_mom_z;
    logic        overflow;

    ponderomotive_boris_momentum_push DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .mode(mode),
        .vec_a_x(vec_a_x), .vec_a_y(vec_a_y), .vec_a_z(vec_a_z),
        .vec_b_x(vec_b_x), .vec_b_y(vec_b_y), .vec_b_z(vec_b_z),
        .particle_charge(particle_charge), .inv_gamma(inv_gamma),
        .out_valid(out_valid), .out_stall(out_stall),
        .new_mom_x(new_mom_x), .new_mom_y(new_mom_y), .new_mom_z(new_mom_z),
        .overflow(overflow)
    );

    // Transactions waiting to be driven, and momenta expected from the block in order.
    push_item_t feed_q[$];
    momentum_t  momentum_due[$];
    int         error_count = 0;

    // Mirror of the block's configuration and held field vectors.
    logic [31:0] mirror_inv_mass;
    logic [30:0] mirror_half_dt;
    logic [30:0] mirror_quarter_dt;
    val_t        field_e[3];
    val_t        field_b[3];
    bit          clamp_seen;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Fixed-point arithmetic of the push. Every clamp sets clamp_seen.
    // ------------------------------------------------------------------
    function automatic val_t clamp_inner(input val_t v);
        if (v > INNER_LIM) begin
            clamp_seen = 1'b1;
            return INNER_LIM;
        end
        if (v < -INNER_LIM) begin
            clamp_seen = 1'b1;
            return -INNER_LIM;
        end
        return v;
    endfunction

    function automatic val_t fx_add(input val_t a, input val_t b);
        return clamp_inner(a + b);
    endfunction

    function automatic val_t fx_sub(input val_t a, input val_t b);
        return clamp_inner(a - b);
    endfunction

    // Exact product, shifted with rounding of the magnitude half away from zero.
    function automatic val_t fx_mul(input val_t a, input val_t b, input int sh);
        logic [63:0]  ma;
        logic [63:0]  mb;
        logic [127:0] prod;
        bit           neg;
        neg = (a < 0) != (b < 0);
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        prod = {64'd0, ma} * {64'd0, mb};
        if (sh > 0)
            prod = prod + (128'd1 << (sh - 1));
        prod = prod >> sh;
        if (prod > {64'd0, INNER_LIM}) begin
            clamp_seen = 1'b1;
            prod = {64'd0, INNER_LIM};
        end
        return neg ? -val_t'(prod[63:0]) : val_t'(prod[63:0]);
    endfunction

    // Nearest value of 2^(2F) / d; d is at least one, so it never divides by zero.
    function automatic val_t fx_recip(input val_t d);
        logic [63:0] num;
        logic [63:0] quo;
        logic [63:0] rm;
        num = 64'd1 << (2 * FRAC_BITS);
        quo = num / d;
        rm = num % d;
        if (rm >= d - rm)
            quo = quo + 64'd1;
        return val_t'(quo);
    endfunction

    // Full Boris push with the ponderomotive half kicks for one particle.
    function automatic momentum_t boris_push(input push_item_t it);
        val_t p[3], gp[3], k[3], u[3], t[3], n[3], r[3][3];
        val_t q, g, c1, c2, alpha, x2, y2, z2, xy, yz, zx, det, inv, v;
        logic [31:0] word[3];
        momentum_t res;
        clamp_seen = 1'b0;
        for (int i = 0; i < 3; i++) begin
            p[i] = val_t'($signed(it.a[i]));
            gp[i] = val_t'($signed(it.b[i]));
        end
        q = val_t'($signed(it.q));
        g = val_t'({47'd0, it.g});
        c1 = fx_mul(q, fx_mul(val_t'({32'd0, mirror_inv_mass}),
                              val_t'({33'd0, mirror_half_dt}), FRAC_BITS), 0);
        c2 = fx_mul(q * q, fx_mul(fx_mul(val_t'({32'd0, mirror_inv_mass}),
                                         val_t'({32'd0, mirror_inv_mass}), FRAC_BITS),
                                  val_t'({33'd0, mirror_quarter_dt}), FRAC_BITS), 0);
        for (int i = 0; i < 3; i++) begin
            k[i] = fx_sub(fx_mul(c1, field_e[i], FRAC_BITS),
                          fx_mul(fx_mul(c2, gp[i], FRAC_BITS), g, GAMMA_FRAC));
            u[i] = fx_add(p[i], k[i]);
        end
        alpha = fx_mul(c1, g, GAMMA_FRAC);
        for (int i = 0; i < 3; i++)
            t[i] = fx_mul(alpha, field_b[i], FRAC_BITS);
        x2 = fx_mul(t[0], t[0], FRAC_BITS);
        y2 = fx_mul(t[1], t[1], FRAC_BITS);
        z2 = fx_mul(t[2], t[2], FRAC_BITS);
        xy = fx_mul(t[0], t[1], FRAC_BITS);
        yz = fx_mul(t[1], t[2], FRAC_BITS);
        zx = fx_mul(t[2], t[0], FRAC_BITS);
        det = fx_add(fx_add(fx_add(ONE_VAL, x2), y2), z2);
        inv = fx_recip(det);

        // Rotation matrix scaled by 1 + |T|^2, built in the block's order of operations.
        r[0][0] = fx_sub(fx_sub(fx_add(ONE_VAL, x2), y2), z2);
        r[1][1] = fx_sub(fx_add(fx_sub(ONE_VAL, x2), y2), z2);
        r[2][2] = fx_add(fx_sub(fx_sub(ONE_VAL, x2), y2), z2);
        r[0][1] = fx_add(xy, t[2]); r[0][1] = fx_add(r[0][1], r[0][1]);
        r[0][2] = fx_sub(zx, t[1]); r[0][2] = fx_add(r[0][2], r[0][2]);
        r[1][0] = fx_sub(xy, t[2]); r[1][0] = fx_add(r[1][0], r[1][0]);
        r[1][2] = fx_add(yz, t[0]); r[1][2] = fx_add(r[1][2], r[1][2]);
        r[2][0] = fx_add(zx, t[1]); r[2][0] = fx_add(r[2][0], r[2][0]);
        r[2][1] = fx_sub(yz, t[0]); r[2][1] = fx_add(r[2][1], r[2][1]);

        for (int i = 0; i < 3; i++)
            n[i] = fx_add(fx_add(fx_mul(r[i][0], u[0], FRAC_BITS),
                                 fx_mul(r[i][1], u[1], FRAC_BITS)),
                          fx_mul(r[i][2], u[2], FRAC_BITS));

        // Second half kick and saturation to the output word.
        for (int i = 0; i < 3; i++) begin
            v = fx_add(k[i], fx_mul(n[i], inv, FRAC_BITS));
            if (v < WORD_MIN) begin
                clamp_seen = 1'b1;
                v = WORD_MIN;
            end else if (v > WORD_MAX) begin
                clamp_seen = 1'b1;
                v = WORD_MAX;
            end
            word[i] = v[31:0];
        end
        res.x = word[0];
        res.y = word[1];
        res.z = word[2];
        res.ovf = clamp_seen;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    // Field values: mostly moderate so that pushes stay in range, with full-range
    // words and the extremes mixed in.
    function automatic logic [31:0] pick_word();
        int sel;
        sel = $urandom_range(0, 15);
        if (sel < 8)
            return 32'($urandom_range(0, 32'h001F_FFFF)) - 32'h0010_0000;
        if (sel < 12)
            return $urandom;
        case ($urandom_range(0, 4))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return 32'h0001_0000;
        endcase
    endfunction

    function automatic push_item_t make_item(input logic m);
        push_item_t it;
        it.mode = m;
        for (int i = 0; i < 3; i++) begin
            it.a[i] = pick_word();
            it.b[i] = pick_word();
        end
        it.q = 8'($urandom_range(0, 255));
        // Inverse gamma mostly at or below one, sometimes above it.
        if ($urandom_range(0, 3) == 0)
            it.g = 17'($urandom_range(0, 131071));
        else
            it.g = 17'($urandom_range(0, 65536));
        return it;
    endfunction

    // Well-formed traffic: a field load now and then, followed by several pushes.
    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++)
            feed_q.push_back(make_item($urandom_range(0, 3) == 0 ? 1'b0 : 1'b1));
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            CFG_INV_MASS:   mirror_inv_mass = data;
            CFG_HALF_DT:    mirror_half_dt = data[30:0];
            CFG_QUARTER_DT: mirror_quarter_dt = data[30:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_config(input logic [31:0] im, input logic [31:0] hdt,
                              input logic [31:0] qdt);
        write_reg(CFG_INV_MASS, im);
        write_reg(CFG_HALF_DT, hdt);
        write_reg(CFG_QUARTER_DT, qdt);
    endtask

    // Holds the sender until every queued transaction is taken and every momentum
    // has come back, then lets the block settle before the next register write.
    task automatic drain();
        while (feed_q.size() > 0 || in_valid || momentum_due.size() > 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: %s mismatch: got %h, expected %h", $time, what, got, want);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of transactions with random gaps in between. The item on
    // the ports is predicted at the edge where the block accepts it.
    // ------------------------------------------------------------------
    push_item_t on_port;
    int         gap_left = 0;
    int         burst_left = 4;

    always @(posedge clk or negedge rst_n) begin
        logic drive_next;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                if (on_port.mode) begin
                    momentum_due.push_back(boris_push(on_port));
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        field_e[i] = val_t'($signed(on_port.a[i]));
                        field_b[i] = val_t'($signed(on_port.b[i]));
                    end
                end
            end
            // A stalled transaction stays on the ports unchanged.
            if (!in_valid || !in_stall) begin
                drive_next = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (feed_q.size() > 0) begin
                    on_port = feed_q.pop_front();
                    drive_next = 1'b1;
                    mode <= on_port.mode;
                    vec_a_x <= on_port.a[0];
                    vec_a_y <= on_port.a[1];
                    vec_a_z <= on_port.a[2];
                    vec_b_x <= on_port.b[0];
                    vec_b_y <= on_port.b[1];
                    vec_b_z <= on_port.b[2];
                    particle_charge <= on_port.q;
                    inv_gamma <= on_port.g;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 700)
                                                               : $urandom_range(0, 4);
                    end
                end
                in_valid <= drive_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: the receiver stalls in segments of its own. A segment is free
    // running, randomly stalled, or stalled throughout.
    // ------------------------------------------------------------------
    int stall_kind = 0;
    int stall_left = 300;

    always @(posedge clk or negedge rst_n) begin
        momentum_t want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (momentum_due.size() == 0) begin
                    $display("%0t ns: result transaction with no push outstanding", $time);
                    error_count++;
                end else begin
                    want = momentum_due.pop_front();
                    if (new_mom_x !== want.x) report_mismatch("new_mom_x", new_mom_x, want.x);
                    if (new_mom_y !== want.y) report_mismatch("new_mom_y", new_mom_y, want.y);
                    if (new_mom_z !== want.z) report_mismatch("new_mom_z", new_mom_z, want.z);
                    if (overflow !== want.ovf)
                        report_mismatch("overflow", 32'(overflow), 32'(want.ovf));
                end
            end
            if (stall_left == 0) begin
                stall_kind = $urandom_range(0, 2);
                stall_left = (stall_kind == 2) ? $urandom_range(1, 150)
                                               : $urandom_range(100, 600);
            end else begin
                stall_left--;
            end
            case (stall_kind)
                0: out_stall <= 1'b0;
                1: out_stall <= 1'($urandom_range(0, 1));
                default: out_stall <= 1'b1;
            endcase
        end
    end

    // Watchdog: the run ends if no transaction moves on either side for too long.
    int idle_cycles = 0;

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial begin
        push_item_t it;
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_INV_MASS;
        cfg_data <= 32'd0;
        mode <= 1'b0;
        vec_a_x <= 32'd0;
        vec_a_y <= 32'd0;
        vec_a_z <= 32'd0;
        vec_b_x <= 32'd0;
        vec_b_y <= 32'd0;
        vec_b_z <= 32'd0;
        particle_charge <= 8'd0;
        inv_gamma <= 17'd0;
        mirror_inv_mass = 32'd65536;
        mirror_half_dt = 31'd0;
        mirror_quarter_dt = 31'd0;
        for (int i = 0; i < 3; i++) begin
            field_e[i] = '0;
            field_b[i] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Reset configuration: a push before any field load sees zero E and B.
        it = make_item(1'b1);
        feed_q.push_back(it);
        queue_random(6);
        drain();

        // Typical step sizes with the directed corner cases.
        set_config(32'h0001_0000, 32'h0000_1000, 32'h0000_0800);
        it = make_item(1'b0);
        it.a = {32'h0000_4000, 32'hFFFF_C000, 32'h0001_0000};
        it.b = {32'h0002_0000, 32'h0000_8000, 32'hFFFF_0000};
        feed_q.push_back(it);
        // Charge and inverse gamma extremes, including a charge of -128 and a gamma
        // factor above one.
        foreach (it.q[j]) begin end
        for (int j = 0; j < 6; j++) begin
            it = make_item(1'b1);
            it.a = {32'h0000_1000, 32'h0000_2000, 32'hFFFF_F000};
            it.b = {32'h0000_0100, 32'hFFFF_FF00, 32'h0000_0080};
            it.q = (j == 0) ? 8'h80 : (j == 1) ? 8'h7F : (j == 2) ? 8'h81 :
                   (j == 3) ? 8'h00 : (j == 4) ? 8'h01 : 8'hFF;
            it.g = (j == 0) ? 17'd0 : (j == 1) ? 17'd65536 : (j == 2) ? 17'h1FFFF :
                   17'($urandom_range(0, 65536));
            feed_q.push_back(it);
        end
        // Momentum and grad phi words at both ends of their range.
        it = make_item(1'b1);
        it.a = {32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000};
        it.b = {32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
        it.q = 8'h7F;
        it.g = 17'h1FFFF;
        feed_q.push_back(it);
        // Field load at the extremes, with charge and gamma fields that must be ignored.
        it = make_item(1'b0);
        it.a = {32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
        it.b = {32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
        it.q = 8'h80;
        it.g = 17'h1FFFF;
        feed_q.push_back(it);
        for (int j = 0; j < 3; j++)
            feed_q.push_back(make_item(1'b1));
        queue_random(140);
        drain();

        // Random configuration, mostly saturating.
        set_config($urandom, $urandom, $urandom);
        queue_random(80);
        drain();

        // Every register at its maximum.
        set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_random(60);
        drain();

        // Every register at zero: no kick and no rotation.
        set_config(32'h0, 32'h0, 32'h0);
        queue_random(60);
        drain();

        // Small random steps for the bulk of the run.
        set_config(32'($urandom_range(0, 32'h0004_0000)), 32'($urandom_range(0, 32'h4000)),
                   32'($urandom_range(0, 32'h4000)));
        queue_random(240);
        drain();

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
